FILE: sv/pdc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 update for the packet deframer.
`default_nettype none
package pdc_pkg;

  localparam int WINDOW_W = 5;
  localparam int POS_W    = 17;
  localparam int TDATA_W  = 80;

  localparam logic [WINDOW_W-1:0] MAX_WINDOW_RESET = 5'd31;
  localparam logic [POS_W-1:0]    POS_MAX          = '1;
  localparam logic [7:0]          TR_CLEAR_MASK    = 8'hDF;
  localparam logic [31:0]         CRC_POLY         = 32'hEDB88320;
  localparam logic [31:0]         CRC_INIT         = 32'hFFFFFFFF;

  // Byte positions inside the datagram.
  localparam logic [POS_W-1:0] POS_SEQ       = 17'd1;
  localparam logic [POS_W-1:0] POS_STAMP     = 17'd4;
  localparam logic [POS_W-1:0] POS_HDR_END   = 17'd8;
  localparam logic [POS_W-1:0] POS_HCRC_LAST = 17'd11;
  localparam logic [POS_W-1:0] POS_HCRC_END  = 17'd12;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_WINDOW   = 2'd1,
    STATUS_CRC_MISMATCH = 2'd2,
    STATUS_BAD_LENGTH   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]          payload_byte;
    logic                payload_valid;
    logic                frame_done;
    status_t             status;
    logic [1:0]          packet_type;
    logic                truncated_flag;
    logic [WINDOW_W-1:0] window_out;
    logic [7:0]          sequence_number;
    logic [15:0]         payload_length;
    logic [31:0]         time_stamp;
  } result_t;

  // Reflected CRC-32 advanced by one byte, least significant bit first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: sv/pdc_parse.sv
// Per-datagram parse state, header capture, CRC checks and result formation.
`default_nettype none
module pdc_parse (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         last_byte,
  input  wire logic                         cfg_we,
  input  wire logic [pdc_pkg::WINDOW_W-1:0] cfg_data,
  output pdc_pkg::result_t                  result
);
  import pdc_pkg::*;

  logic [WINDOW_W-1:0] max_window;
  logic [POS_W-1:0]    pos;
  logic [31:0]         running_crc;
  logic [31:0]         received_crc;
  logic [7:0]          first_hdr;
  logic [7:0]          seq_store;
  logic [15:0]         length_store;
  logic [31:0]         stamp_store;
  status_t             first_error;

  logic [POS_W-1:0]    pos_next;
  logic [31:0]         running_crc_next;
  logic [31:0]         received_crc_next;
  logic [7:0]          first_hdr_next;
  logic [7:0]          seq_store_next;
  logic [15:0]         length_store_next;
  logic [31:0]         stamp_store_next;
  status_t             first_error_next;

  status_t             new_err;
  logic [31:0]         rx_word;
  logic                crc_bad;
  logic [POS_W-1:0]    len_ext;
  logic [POS_W-1:0]    pay_end;
  logic [POS_W-1:0]    len_upd_ext;
  logic                ok_end;
  logic                in_payload;

  assign rx_word = {received_crc[23:0], data_byte};
  assign crc_bad = (~running_crc) != rx_word;
  assign len_ext = {1'b0, length_store};
  assign pay_end = POS_HCRC_END + len_ext;

  always_comb begin
    running_crc_next  = running_crc;
    received_crc_next = received_crc;
    first_hdr_next    = first_hdr;
    seq_store_next    = seq_store;
    length_store_next = length_store;
    stamp_store_next  = stamp_store;
    new_err           = STATUS_OK;
    in_payload        = 1'b0;

    if (pos < POS_HDR_END) begin
      running_crc_next = crc32_byte(running_crc,
                                    (pos == '0) ? (data_byte & TR_CLEAR_MASK) : data_byte);
      if (pos == '0) begin
        first_hdr_next = data_byte;
        if (data_byte[WINDOW_W-1:0] > max_window) begin
          new_err = STATUS_BAD_WINDOW;
        end
      end else if (pos == POS_SEQ) begin
        seq_store_next = data_byte;
      end else if (pos < POS_STAMP) begin
        length_store_next = {length_store[7:0], data_byte};
      end else begin
        stamp_store_next = stamp_store | ({24'd0, data_byte} << {pos[1:0], 3'b000});
      end
    end else if (pos < POS_HCRC_END) begin
      received_crc_next = rx_word;
      if (pos == POS_HCRC_LAST) begin
        if (crc_bad) begin
          new_err = STATUS_CRC_MISMATCH;
        end
        running_crc_next  = CRC_INIT;
        received_crc_next = '0;
      end
    end else if (length_store != '0 && pos < pay_end) begin
      running_crc_next = crc32_byte(running_crc, data_byte);
      in_payload       = 1'b1;
    end else if (length_store != '0 && pos < pay_end + POS_W'(4)) begin
      received_crc_next = rx_word;
      if (pos == pay_end + POS_W'(3) && crc_bad) begin
        new_err = STATUS_CRC_MISMATCH;
      end
    end

    first_error_next = first_error;
    if (first_error == STATUS_OK) begin
      first_error_next = new_err;
    end

    if (pos != POS_MAX) begin
      pos_next = pos + POS_W'(1);
    end else begin
      pos_next = pos;
    end
  end

  // End-of-datagram check uses the length as updated by this very byte.
  always_comb begin
    len_upd_ext = {1'b0, length_store_next};
    if (length_store_next == '0) begin
      ok_end = (pos == POS_HCRC_LAST);
    end else begin
      ok_end = (pos == POS_HCRC_LAST + len_upd_ext) ||
               (pos == POS_HCRC_LAST + POS_W'(4) + len_upd_ext);
    end
  end

  always_comb begin
    result               = '0;
    result.payload_valid = in_payload;
    result.payload_byte  = in_payload ? data_byte : 8'd0;
    if (last_byte) begin
      result.frame_done      = 1'b1;
      result.status          = (first_error_next != STATUS_OK) ? first_error_next :
                               (ok_end ? STATUS_OK : STATUS_BAD_LENGTH);
      result.packet_type     = first_hdr_next[7:6];
      result.truncated_flag  = first_hdr_next[5];
      result.window_out      = first_hdr_next[WINDOW_W-1:0];
      result.sequence_number = seq_store_next;
      result.payload_length  = length_store_next;
      result.time_stamp      = stamp_store_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_window <= MAX_WINDOW_RESET;
    end else if (cfg_we) begin
      max_window <= cfg_data;
    end
  end

  // Every datagram starts from the reset state once its last byte is taken.
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      pos          <= '0;
      running_crc  <= CRC_INIT;
      received_crc <= '0;
      first_hdr    <= '0;
      seq_store    <= '0;
      length_store <= '0;
      stamp_store  <= '0;
      first_error  <= STATUS_OK;
    end else if (step) begin
      pos          <= pos_next;
      running_crc  <= running_crc_next;
      received_crc <= received_crc_next;
      first_hdr    <= first_hdr_next;
      seq_store    <= seq_store_next;
      length_store <= length_store_next;
      stamp_store  <= stamp_store_next;
      first_error  <= first_error_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/pdc_out_stage.sv
// Output register that holds one result beat and frees itself when it is taken.
`default_nettype none
module pdc_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  pdc_pkg::result_t      in_result,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pdc_pkg::result_t      out_result
);
  import pdc_pkg::*;

  result_t held;
  logic    valid;

  // The register can load whenever it is empty or is being emptied this cycle.
  assign in_ready   = !valid || out_ready;
  assign out_valid  = valid;
  assign out_result = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_result;
    end
  end

endmodule
`default_nettype wire

FILE: sv/packet_deframer_crc32.sv
// Top level of the byte-serial packet deframer with header and payload CRC-32 checks.
// Usage:
// Datagram bytes enter on the s_axis channel, one byte per beat, with s_axis_tlast
// on the final byte. Every accepted beat produces exactly one m_axis beat.
// On payload bytes m_axis_tuser is set and the byte appears in the low tdata bits.
// On the beat that answers the final byte m_axis_tlast is set and tdata carries the
// status and the header fields; all those fields read zero on other beats.
// The result of a byte is registered at the edge that accepts it.
// Throughput is one byte per cycle while the receiver takes each beat; the byte-wide
// CRC-32 update and header capture sit between the parse state registers and the output register.
// When the receiver stalls, the output register holds its beat and s_axis_tready
// drops only while that register is full and not being taken.
// Reset clears the parse state, empties the output register and sets max_window to 31.
// The user must write max_window via cfg_we/cfg_data only while no datagram is in flight; unenforced.
`default_nettype none
module packet_deframer_crc32 (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [pdc_pkg::WINDOW_W-1:0] cfg_data,       // max_window
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,   // data_byte
  input  wire logic                         s_axis_tlast,   // last_byte
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // From bit 0 up: payload_byte[7:0], status[9:8], packet_type[11:10],
  // truncated_flag[12], window_out[17:13], sequence_number[25:18],
  // payload_length[41:26], time_stamp[73:42], zero fill[79:74].
  output logic [pdc_pkg::TDATA_W-1:0]       m_axis_tdata,
  output logic                              m_axis_tuser,   // payload_valid
  output logic                              m_axis_tlast    // frame_done
);
  import pdc_pkg::*;

  result_t step_result;
  result_t out_result;
  logic    step;

  // A byte advances the parser only on the beat that the output stage accepts.
  assign step = s_axis_tvalid && s_axis_tready;

  pdc_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (s_axis_tdata),
    .last_byte (s_axis_tlast),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .result    (step_result)
  );

  pdc_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_result  (step_result),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (out_result)
  );

  // Pack the registered result onto the stream fields.
  assign m_axis_tdata = {6'd0,
                         out_result.time_stamp,
                         out_result.payload_length,
                         out_result.sequence_number,
                         out_result.window_out,
                         out_result.truncated_flag,
                         out_result.packet_type,
                         out_result.status,
                         out_result.payload_byte};
  assign m_axis_tuser = out_result.payload_valid;
  assign m_axis_tlast = out_result.frame_done;

endmodule
`default_nettype wire
